// ===== rtl/bmem_pkg.sv =====
package bmem_pkg;

  localparam int ADDR_BITS_DEF   = 16;
  localparam int BYTE_BITS       = 8;
  localparam int BYTES_PER_WORD  = 16;
  localparam int BYTE_IDX_BITS   = $clog2(BYTES_PER_WORD);
  localparam int WORD_BITS       = BYTES_PER_WORD * BYTE_BITS;
  localparam int MAX_BURST       = 16;

  localparam int ADDR_FIELD_BITS = 16;
  localparam int WDATA_BITS      = 32;
  localparam int WDATA_BYTES     = WDATA_BITS / BYTE_BITS;
  localparam int IN_DATA_BITS    = ADDR_FIELD_BITS + WDATA_BITS;

  localparam int BURST_BITS      = 5;
  localparam int LAT_BITS        = 8;
  localparam int APB_ADDR_BITS   = 3;
  localparam int APB_DATA_BITS   = 32;

  localparam logic [BURST_BITS-1:0] BURST_RESET = 5'd4;
  localparam logic [LAT_BITS-1:0]   LAT_RESET   = 8'd1;

  // register index taken from paddr[2]
  localparam logic REG_BURST_WORDS    = 1'b0;
  localparam logic REG_ACCESS_LATENCY = 1'b1;

  // request kinds carried in s_tuser
  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

endpackage

// ===== rtl/bmem_ram.sv =====
module bmem_ram #(
  parameter int WIDTH  = 8,
  parameter int ADDR_W = 16
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [WIDTH-1:0]  wdata,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/burst_read_byte_memory.sv =====
// Byte-addressed memory with single-word writes and burst reads, one byte per cycle; a stalled
// output holds a read between words. A request first counts down access_latency in the wait
// state; a write then does 4 byte writes and one push, and a read word 16 byte reads through
// the one RAM port, one flush and one push. Only one request is in progress at a time.
// Reset: synchronous; then clears every byte of the store, s_tready low meanwhile.
// Registers reset to burst_words = 4, access_latency = 1.
module burst_read_byte_memory
  import bmem_pkg::*;
#(
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  // slave side
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [IN_DATA_BITS-1:0]  s_tdata,   // address[15:0], write_data[47:16]
  input  logic                     s_tuser,   // kind
  // master side
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [WORD_BITS-1:0]     m_tdata,   // data_low[63:0], data_high[127:64]
  output logic                     m_tuser,   // is_write_ack
  output logic                     m_tlast,   // last_in_burst
  // configuration
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_WAIT  = 3'd2;
  localparam logic [2:0] ST_WRITE = 3'd3;
  localparam logic [2:0] ST_READ  = 3'd4;
  localparam logic [2:0] ST_FLUSH = 3'd5;
  localparam logic [2:0] ST_PUSH  = 3'd6;

  logic [2:0]               state;
  logic [ADDR_BITS-1:0]     ptr;
  logic [LAT_BITS-1:0]      lat_cnt;
  logic                     kind_r;
  logic [WDATA_BITS-1:0]    wr_data;
  logic [BYTE_IDX_BITS-1:0] byte_cnt;
  logic [BURST_BITS-1:0]    word_cnt;
  logic                     rd_valid;
  logic [WORD_BITS-1:0]     asm_data;
  logic [BURST_BITS-1:0]    burst_words;
  logic [LAT_BITS-1:0]      access_latency;
  logic                     out_valid;
  logic [WORD_BITS-1:0]     out_data;
  logic                     out_user;
  logic                     out_last;

  logic                     ram_we;
  logic [BYTE_BITS-1:0]     ram_wdata;
  logic [BYTE_BITS-1:0]     ram_rdata;
  logic [BURST_BITS-1:0]    eff_count;
  logic                     last_word;
  logic                     cfg_write;

  bmem_ram #(
    .WIDTH  (BYTE_BITS),
    .ADDR_W (ADDR_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ptr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign ram_we    = (state == ST_CLEAR) || (state == ST_WRITE);
  assign ram_wdata = (state == ST_CLEAR) ? '0 : wr_data[BYTE_BITS-1:0];

  assign eff_count = (burst_words > BURST_BITS'(MAX_BURST)) ? BURST_BITS'(MAX_BURST)
                                                            : burst_words;
  assign last_word = (word_cnt + BURST_BITS'(1)) == eff_count;

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;
  assign m_tuser  = out_user;
  assign m_tlast  = out_last;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    case (paddr[2])
      REG_BURST_WORDS:    prdata = APB_DATA_BITS'(burst_words);
      REG_ACCESS_LATENCY: prdata = APB_DATA_BITS'(access_latency);
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      burst_words    <= BURST_RESET;
      access_latency <= LAT_RESET;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_BURST_WORDS:    burst_words    <= pwdata[BURST_BITS-1:0];
        REG_ACCESS_LATENCY: access_latency <= pwdata[LAT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // collect bytes from the top so the first byte read ends up lowest
  always_ff @(posedge clk) begin
    if (rd_valid) begin
      asm_data <= {ram_rdata, asm_data[WORD_BITS-1:BYTE_BITS]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      ptr       <= '0;
      rd_valid  <= 1'b0;
      out_valid <= 1'b0;
      byte_cnt  <= '0;
      word_cnt  <= '0;
      lat_cnt   <= '0;
    end else begin
      rd_valid <= (state == ST_READ);
      // the push state loads the next word itself
      if (out_valid && m_tready && (state != ST_PUSH)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          ptr <= ptr + 1'b1;
          if (&ptr) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_tvalid) begin
            kind_r  <= s_tuser;
            ptr     <= ADDR_BITS'(s_tdata[ADDR_FIELD_BITS-1:0]);
            wr_data <= s_tdata[IN_DATA_BITS-1:ADDR_FIELD_BITS];
            lat_cnt <= access_latency;
            state   <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (lat_cnt == '0) begin
            byte_cnt <= '0;
            word_cnt <= '0;
            if (kind_r == KIND_WRITE) begin
              state <= ST_WRITE;
            end else if (eff_count == '0) begin
              state <= ST_IDLE;
            end else begin
              state <= ST_READ;
            end
          end else begin
            lat_cnt <= lat_cnt - 1'b1;
          end
        end
        ST_WRITE: begin
          ptr      <= ptr + 1'b1;
          wr_data  <= wr_data >> BYTE_BITS;
          byte_cnt <= byte_cnt + 1'b1;
          if (byte_cnt == BYTE_IDX_BITS'(WDATA_BYTES - 1)) begin
            state <= ST_PUSH;
          end
        end
        ST_READ: begin
          ptr      <= ptr + 1'b1;
          byte_cnt <= byte_cnt + 1'b1;
          if (byte_cnt == BYTE_IDX_BITS'(BYTES_PER_WORD - 1)) begin
            state <= ST_FLUSH;
          end
        end
        ST_FLUSH: begin
          // last byte lands in the assembly register this cycle
          state <= ST_PUSH;
        end
        ST_PUSH: begin
          if (!out_valid || m_tready) begin
            out_valid <= 1'b1;
            out_data  <= (kind_r == KIND_WRITE) ? '0 : asm_data;
            out_user  <= (kind_r == KIND_WRITE);
            out_last  <= (kind_r == KIND_WRITE) || last_word;
            byte_cnt  <= '0;
            word_cnt  <= word_cnt + 1'b1;
            if ((kind_r == KIND_WRITE) || last_word) begin
              state <= ST_IDLE;
            end else begin
              state <= ST_READ;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/bmem_check.sv =====
module bmem_check
  import bmem_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     s_tvalid,
  input logic                     s_tready,
  input logic                     m_tvalid,
  input logic                     m_tready,
  input logic [WORD_BITS-1:0]     m_tdata,
  input logic                     m_tuser,
  input logic                     m_tlast
);

  // store clearing keeps the input closed right after reset
  a_clear_after_reset: assert property (@(posedge clk) rst |=> !s_tready)
    else $error("input open right after reset");

  // one request at a time
  a_one_request: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second word accepted while a request is in progress");

  // write acknowledge is a single final word with zero data
  a_ack_shape: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tlast && (m_tdata == '0)))
    else $error("malformed write acknowledge");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("stalled output word changed");

endmodule

bind burst_read_byte_memory bmem_check u_bmem_check (.*);

// ===== tb/tb_top.sv =====
module tb_top;
  import bmem_pkg::*;

  localparam int WATCHDOG_LIMIT  = 200000;
  localparam int STORE_BYTES     = 2 ** ADDR_BITS_DEF;
  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 50;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     s_tvalid = 1'b0;
  logic                     s_tready;
  logic [IN_DATA_BITS-1:0]  s_tdata = '0;   // address[15:0], write_data[47:16]
  logic                     s_tuser = 1'b0; // kind
  logic                     m_tvalid;
  logic                     m_tready = 1'b0;
  logic [WORD_BITS-1:0]     m_tdata;        // data_low[63:0], data_high[127:64]
  logic                     m_tuser;        // is_write_ack
  logic                     m_tlast;        // last_in_burst
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [APB_ADDR_BITS-1:0] paddr = '0;
  logic [APB_DATA_BITS-1:0] pwdata = '0;
  logic [APB_DATA_BITS-1:0] prdata;
  logic                     pready;

  burst_read_byte_memory #(.ADDR_BITS(ADDR_BITS_DEF)) DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  typedef struct {
    logic [63:0] data_low;
    logic [63:0] data_high;
    logic        is_write_ack;
    logic        last_in_burst;
  } mem_reply_t;

  mem_reply_t                pending_replies[$];
  logic [BYTE_BITS-1:0]      mem_image[STORE_BYTES];
  logic [BURST_BITS-1:0]     cfg_burst = BURST_RESET;
  logic [LAT_BITS-1:0]       cfg_latency = LAT_RESET;

  int  error_count = 0;
  int  request_count = 0;
  int  read_count = 0;
  int  write_count = 0;
  int  reply_count = 0;
  int  setting_count = 0;
  int  idle_cycles = 0;
  int  sink_stall = 0;
  bit  src_idle_on = 1'b0;
  bit  sink_idle_on = 1'b0;

  // mostly short gaps, now and then a long one
  function automatic int pick_gap(bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void compute_replies(logic kind, logic [15:0] addr, logic [31:0] wdata);
    mem_reply_t r;
    int         count;
    logic [15:0] a;
    if (kind == KIND_WRITE) begin
      for (int b = 0; b < WDATA_BYTES; b++) begin
        a = addr + 16'(b);
        mem_image[a] = wdata[8*b +: 8];
      end
      r.data_low = '0;
      r.data_high = '0;
      r.is_write_ack = 1'b1;
      r.last_in_burst = 1'b1;
      pending_replies.push_back(r);
    end else begin
      count = (cfg_burst > MAX_BURST) ? MAX_BURST : int'(cfg_burst);
      for (int w = 0; w < count; w++) begin
        for (int b = 0; b < 8; b++) begin
          a = addr + 16'(BYTES_PER_WORD * w + b);
          r.data_low[8*b +: 8] = mem_image[a];
          a = addr + 16'(BYTES_PER_WORD * w + 8 + b);
          r.data_high[8*b +: 8] = mem_image[a];
        end
        r.is_write_ack = 1'b0;
        r.last_in_burst = (w == count - 1);
        pending_replies.push_back(r);
      end
    end
  endfunction

  // called at a rising edge; returns at the edge where the word was taken
  task automatic send_request(logic kind, logic [15:0] addr, logic [31:0] wdata);
    int gap;
    gap = pick_gap(src_idle_on);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {wdata, addr};
    s_tuser <= kind;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    compute_replies(kind, addr, wdata);
    request_count++;
    if (kind == KIND_WRITE) write_count++;
    else read_count++;
  endtask

  // drop valid, wait out every reply, then leave room for work that gives no reply
  task automatic drain;
    s_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (int'(cfg_latency) + 64) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (idx == REG_BURST_WORDS) cfg_burst = value[BURST_BITS-1:0];
    else cfg_latency = value[LAT_BITS-1:0];
    @(posedge clk);
  endtask

  task automatic read_reg(logic idx);
    logic [31:0] want;
    want = (idx == REG_BURST_WORDS) ? 32'(cfg_burst) : 32'(cfg_latency);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== want) begin
      $display("%0t: register %0d readback: expected %h actual %h", $time, idx, want, prdata);
      error_count++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(logic [31:0] burst_value, logic [31:0] latency_value);
    write_reg(REG_BURST_WORDS, burst_value);
    write_reg(REG_ACCESS_LATENCY, latency_value);
    read_reg(REG_BURST_WORDS);
    read_reg(REG_ACCESS_LATENCY);
    setting_count++;
  endtask

  // check every reply word against the oldest prediction; pick the next ready
  always @(posedge clk) begin
    mem_reply_t want;
    if (!rst && m_tvalid && m_tready) begin
      reply_count++;
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected reply: expected none actual data %h ack %b last %b",
                 $time, m_tdata, m_tuser, m_tlast);
        error_count++;
      end else begin
        want = pending_replies.pop_front();
        if (m_tdata[63:0] !== want.data_low) begin
          $display("%0t: data_low: expected %h actual %h", $time, want.data_low,
                   m_tdata[63:0]);
          error_count++;
        end
        if (m_tdata[127:64] !== want.data_high) begin
          $display("%0t: data_high: expected %h actual %h", $time, want.data_high,
                   m_tdata[127:64]);
          error_count++;
        end
        if (m_tuser !== want.is_write_ack) begin
          $display("%0t: is_write_ack: expected %b actual %b", $time, want.is_write_ack,
                   m_tuser);
          error_count++;
        end
        if (m_tlast !== want.last_in_burst) begin
          $display("%0t: last_in_burst: expected %b actual %b", $time, want.last_in_burst,
                   m_tlast);
          error_count++;
        end
      end
    end
    if (!sink_idle_on) begin
      m_tready <= 1'b1;
    end else if (sink_stall > 0) begin
      m_tready <= 1'b0;
      sink_stall--;
    end else begin
      sink_stall = pick_gap(1'b1);
      m_tready <= (sink_stall == 0);
      if (sink_stall > 0) sink_stall--;
    end
  end

  // the clearing pass after reset counts as silence, hence the wide limit
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d replies still due", $time,
               idle_cycles, pending_replies.size());
      $display("burst_read_byte_memory test failed");
      $finish;
    end
  end

  task automatic test_reset_values;
    read_reg(REG_BURST_WORDS);
    read_reg(REG_ACCESS_LATENCY);
  endtask

  task automatic test_directed;
    src_idle_on = 1'b0;
    sink_idle_on = 1'b0;
    // cleared store, default burst of four, one read wrapping past the top
    send_request(KIND_READ, 16'h0000, 32'h0);
    send_request(KIND_READ, 16'hFFF8, 32'hFFFF_FFFF);
    send_request(KIND_WRITE, 16'h0000, 32'hFFFF_FFFF);
    send_request(KIND_WRITE, 16'hFFFE, 32'h1122_3344);   // word wraps into bytes 0 and 1
    send_request(KIND_WRITE, 16'h0010, 32'h0000_0000);
    send_request(KIND_WRITE, 16'h0013, 32'hA5C3_5A3C);
    send_request(KIND_WRITE, 16'hFFF0, 32'h8000_0001);
    send_request(KIND_READ, 16'hFFF0, 32'h0);
    send_request(KIND_READ, 16'h0001, 32'h0);
    drain();
    configure(32'd1, 32'd0);
    send_request(KIND_READ, 16'h0000, 32'h0);
    send_request(KIND_WRITE, 16'h0004, 32'hDEAD_BEEF);
    send_request(KIND_READ, 16'h0000, 32'h0);
    drain();
    configure(32'd16, 32'd255);
    send_request(KIND_READ, 16'hFF80, 32'h0);           // burst wraps halfway
    send_request(KIND_WRITE, 16'hFFFF, 32'h0102_0304);
    drain();
    // zero length: a read gives nothing, a write still acknowledges
    configure(32'd0, 32'd3);
    send_request(KIND_READ, 16'h0000, 32'h0);
    send_request(KIND_WRITE, 16'h0020, 32'h5555_AAAA);
    send_request(KIND_READ, 16'h0020, 32'h0);
    drain();
    // oversized lengths are cut to sixteen words; upper register bits dropped
    configure(32'd31, 32'd0);
    send_request(KIND_READ, 16'hFFF0, 32'h0);
    drain();
    configure(32'hDEAD_BE11, 32'hDEAD_BE07);
    send_request(KIND_READ, 16'h1230, 32'h0);
    drain();
  endtask

  task automatic test_random;
    logic [31:0] burst_value, latency_value, wdata;
    logic [15:0] window, addr;
    logic        kind;
    int          r;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: begin burst_value = 1; latency_value = 0; end
        1: begin burst_value = 4; latency_value = 1; end
        2: begin burst_value = 16; latency_value = 0; end
        3: begin burst_value = 2; latency_value = 255; end
        4: begin burst_value = 0; latency_value = $urandom_range(0, 255); end
        5: begin burst_value = $urandom; latency_value = $urandom; end
        6: begin burst_value = 3; latency_value = 0; end
        default: begin
          burst_value = $urandom_range(1, 8);
          latency_value = $urandom_range(0, 20);
        end
      endcase
      configure(burst_value, latency_value);
      src_idle_on = (ph != 6);
      sink_idle_on = (ph != 0 && ph != 6);
      window = (ph == 3) ? 16'hFF80 : 16'($urandom);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        r = $urandom_range(0, 99);
        wdata = $urandom;
        // most traffic stays in a small window so reads see earlier writes
        if (r < 45) begin
          kind = KIND_WRITE;
          addr = window + 16'($urandom_range(0, 127));
        end else if (r < 85) begin
          kind = KIND_READ;
          addr = window + 16'($urandom_range(0, 127));
        end else begin
          kind = $urandom_range(0, 1) ? KIND_WRITE : KIND_READ;
          addr = 16'($urandom);
        end
        send_request(kind, addr, wdata);
      end
      drain();
    end
  endtask

  initial begin
    foreach (mem_image[i]) mem_image[i] = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // hold off until the store has been cleared
    while (!s_tready) @(posedge clk);
    test_reset_values();
    test_directed();
    test_random();
    drain();
    $display("covered %0d requests (%0d reads, %0d writes) over %0d register settings",
             request_count, read_count, write_count, setting_count);
    $display("checked %0d reply words, %0d mismatches", reply_count, error_count);
    if (error_count == 0 && pending_replies.size() == 0) begin
      $display("burst_read_byte_memory test passed");
    end else begin
      $display("burst_read_byte_memory test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/bmem_pkg.sv
rtl/bmem_ram.sv
rtl/burst_read_byte_memory.sv
rtl/bmem_check.sv
tb/tb_top.sv
